@@ rtl/nvpc_pkg.sv @@
// Shared types, codes and arithmetic constants of the needle valve position controller.
package nvpc_pkg;

    localparam int C_CFG_W    = 16;
    localparam int C_IDX_W    = 3;
    localparam int C_POS_W    = 16;
    localparam int C_CUR_W    = 8;
    localparam int C_STEPS_W  = 26;
    localparam int C_MAG_W    = 17;
    localparam int C_SPC_W    = 11;
    localparam int C_PROD_W   = C_MAG_W + C_SPC_W;
    localparam int C_SUM_W    = C_PROD_W + 1;
    localparam int C_RECIP_SH = 30;
    localparam int C_RECIP_W  = 27;
    localparam logic [C_RECIP_W-1:0] C_RECIP_TEN = 27'd107374183;

    localparam logic [1:0] ST_INTERMED = 2'd0;
    localparam logic [1:0] ST_OPENED   = 2'd1;
    localparam logic [1:0] ST_CLOSED   = 2'd2;
    localparam logic [1:0] ST_LOOSE    = 2'd3;

    localparam logic [2:0] MV_NONE  = 3'd0;
    localparam logic [2:0] MV_OPEN  = 3'd1;
    localparam logic [2:0] MV_CLOSE = 3'd2;
    localparam logic [2:0] MV_TIGHT = 3'd3;
    localparam logic [2:0] MV_STOP  = 3'd4;

    localparam logic [1:0] GC_KEEP  = 2'd0;
    localparam logic [1:0] GC_OPEN  = 2'd1;
    localparam logic [1:0] GC_CLOSE = 2'd2;

    localparam logic [1:0] DC_NONE      = 2'd0;
    localparam logic [1:0] DC_STOP      = 2'd1;
    localparam logic [1:0] DC_MOVE      = 2'd2;
    localparam logic [1:0] DC_STOP_MOVE = 2'd3;

    localparam logic [C_IDX_W-1:0] CFG_OPEN_THR    = 3'd0;
    localparam logic [C_IDX_W-1:0] CFG_LOOSE_THR   = 3'd1;
    localparam logic [C_IDX_W-1:0] CFG_CLOSED_THR  = 3'd2;
    localparam logic [C_IDX_W-1:0] CFG_MIN_TIGHTEN = 3'd3;
    localparam logic [C_IDX_W-1:0] CFG_OPEN_CUR    = 3'd4;
    localparam logic [C_IDX_W-1:0] CFG_CLOSE_CUR   = 3'd5;

    typedef struct packed {
        logic [C_POS_W-1:0] open_thr;
        logic [C_POS_W-1:0] loose_thr;
        logic [C_POS_W-1:0] closed_thr;
        logic [C_POS_W-1:0] min_tighten;
        logic [C_CUR_W-1:0] open_cur;
        logic [C_CUR_W-1:0] close_cur;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         goal_command;
        logic               enable;
        logic [C_POS_W-1:0] position_reading;
        logic               drive_busy;
        logic               stop_accepted;
    } t_item;

    typedef struct packed {
        logic [1:0]          drive_command;
        logic                neg;
        logic                frac;
        logic [C_PROD_W-1:0] mag_prod;
        logic [C_CUR_W-1:0]  move_current;
        logic [1:0]          valve_state;
        logic [1:0]          valve_goal;
        logic                is_moving;
    } t_mid;

endpackage

@@ rtl/nvpc_ctrl.sv @@
// Valve state classification, goal tracking, move selection and move magnitude product.
module nvpc_ctrl #(
    parameter int ENCODER_MAX     = 65535,
    parameter int ENCODER_MIN     = 0,
    parameter int STEPS_PER_COUNT = 250
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  nvpc_pkg::t_cfg   i_cfg,
    input  nvpc_pkg::t_item  i_item,
    output nvpc_pkg::t_mid   o_mid
);
    import nvpc_pkg::*;

    localparam logic signed [17:0]        L_EMAX = 18'(ENCODER_MAX);
    localparam logic signed [17:0]        L_EMIN = 18'(ENCODER_MIN);
    localparam logic        [C_SPC_W-1:0] L_SPC  = C_SPC_W'(STEPS_PER_COUNT);

    logic [1:0] r_state, n_state;
    logic [1:0] r_prev;
    logic [1:0] r_goal, n_goal;
    logic [2:0] r_kind, n_kind;
    logic       r_moving, n_moving;
    logic       r_tight, n_tight;

    logic               newstate;
    logic               do_move;
    logic [1:0]         dcmd;
    logic [C_CUR_W-1:0] cur;
    logic               is_open;
    logic               is_close;
    logic               is_tight;

    logic signed [17:0]  pos_s;
    logic signed [17:0]  d1;
    logic signed [17:0]  d2;
    logic signed [21:0]  d1_x11;
    logic signed [21:0]  d2_x10;
    logic                lt;
    logic signed [17:0]  chosen;
    logic signed [17:0]  chosen_abs;
    logic [C_POS_W-1:0]  over;
    logic [C_MAG_W-1:0]  tmag;
    logic [C_MAG_W-1:0]  mag;

    always_comb begin
        n_goal = r_goal;
        case (i_item.goal_command)
            GC_OPEN: begin
                n_goal = ST_OPENED;
            end
            GC_CLOSE: begin
                n_goal = (r_state inside {ST_OPENED, ST_INTERMED}) ? ST_LOOSE : ST_CLOSED;
            end
            default: begin
                n_goal = r_goal;
            end
        endcase

        if (i_item.position_reading <= i_cfg.closed_thr && r_tight) begin
            n_state = ST_CLOSED;
        end else if (i_item.position_reading <= i_cfg.loose_thr) begin
            n_state = ST_LOOSE;
        end else if (i_item.position_reading >= i_cfg.open_thr) begin
            n_state = ST_OPENED;
        end else begin
            n_state = ST_INTERMED;
        end

        newstate = (n_state != r_prev);
        n_kind   = r_kind;
        n_moving = r_moving;
        n_tight  = r_tight;

        if (n_state == n_goal) begin
            n_kind   = MV_NONE;
            n_moving = 1'b0;
            if (n_state == ST_LOOSE) begin
                n_goal = ST_CLOSED;
                n_kind = MV_TIGHT;
            end
        end else if (!r_moving) begin
            if (n_state != ST_OPENED && n_goal == ST_OPENED) begin
                n_kind = MV_OPEN;
            end else if (n_state != ST_CLOSED && (n_goal == ST_CLOSED || n_goal == ST_LOOSE)) begin
                n_kind = MV_CLOSE;
            end
        end

        do_move = newstate || (r_goal != n_goal);
        if (!i_item.enable) begin
            do_move = 1'b1;
            n_kind  = MV_STOP;
            n_goal  = ST_INTERMED;
        end

        dcmd     = DC_NONE;
        cur      = '0;
        is_open  = 1'b0;
        is_close = 1'b0;
        is_tight = 1'b0;
        if (do_move) begin
            case (n_kind)
                MV_STOP: begin
                    dcmd = DC_STOP;
                    if (i_item.stop_accepted) begin
                        n_moving = 1'b0;
                    end
                end
                MV_NONE: begin
                    if (n_state != ST_CLOSED) begin
                        dcmd = DC_STOP;
                    end
                    n_moving = 1'b0;
                end
                MV_OPEN: begin
                    dcmd     = DC_MOVE;
                    cur      = i_cfg.open_cur;
                    is_open  = 1'b1;
                    n_moving = 1'b1;
                    n_tight  = 1'b0;
                end
                MV_CLOSE: begin
                    dcmd     = DC_MOVE;
                    cur      = i_cfg.close_cur;
                    is_close = 1'b1;
                    n_moving = 1'b1;
                end
                MV_TIGHT: begin
                    if (!n_moving) begin
                        dcmd     = DC_STOP_MOVE;
                        cur      = i_cfg.close_cur;
                        is_tight = 1'b1;
                        n_tight  = 1'b1;
                        n_moving = 1'b1;
                    end else if (!i_item.drive_busy) begin
                        n_moving = 1'b0;
                    end
                end
                default: begin
                    dcmd = DC_NONE;
                end
            endcase
        end
    end

    always_comb begin
        pos_s = {2'b00, i_item.position_reading};
        if (is_open) begin
            d1 = $signed({2'b00, i_cfg.open_thr}) - pos_s;
            d2 = L_EMAX - pos_s;
        end else begin
            d1 = pos_s - $signed({2'b00, i_cfg.loose_thr});
            d2 = pos_s - L_EMIN;
        end
        d1_x11     = 22'(d1) * 22'sd11;
        d2_x10     = 22'(d2) * 22'sd10;
        lt         = (d1_x11 < d2_x10);
        chosen     = lt ? d1 : d2;
        chosen_abs = chosen[17] ? -chosen : chosen;
        over = (i_item.position_reading > i_cfg.closed_thr) ?
               (i_item.position_reading - i_cfg.closed_thr) : '0;
        tmag = {1'b0, over} + {1'b0, i_cfg.min_tighten};
        mag  = is_tight ? tmag : chosen_abs[C_MAG_W-1:0];

        o_mid.drive_command = dcmd;
        o_mid.neg           = is_tight | (is_open & chosen[17]) | (is_close & ~chosen[17]);
        o_mid.frac          = ~is_tight & lt;
        o_mid.mag_prod      = (is_open | is_close | is_tight) ?
                              (C_PROD_W'(L_SPC) * C_PROD_W'(mag)) : '0;
        o_mid.move_current  = cur;
        o_mid.valve_state   = n_state;
        o_mid.valve_goal    = n_goal;
        o_mid.is_moving     = n_moving;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INTERMED;
            r_prev   <= ST_INTERMED;
            r_goal   <= ST_INTERMED;
            r_kind   <= MV_NONE;
            r_moving <= 1'b0;
            r_tight  <= 1'b1;
        end else if (i_fire) begin
            r_state  <= n_state;
            r_prev   <= n_state;
            r_goal   <= n_goal;
            r_kind   <= n_kind;
            r_moving <= n_moving;
            r_tight  <= n_tight;
        end
    end

endmodule

@@ rtl/nvpc_scale.sv @@
// Overshoot scaling by eleven tenths when the frac flag is set, and saturation of the signed step count.
module nvpc_scale (
    input  nvpc_pkg::t_mid                         i_mid,
    output logic signed [nvpc_pkg::C_STEPS_W-1:0]  o_steps
);
    import nvpc_pkg::*;

    localparam int L_PW = C_PROD_W + C_RECIP_W;
    localparam int L_QW = L_PW - C_RECIP_SH;
    localparam logic [C_SUM_W-1:0] L_POS_LIM = C_SUM_W'((2 ** (C_STEPS_W - 1)) - 1);
    localparam logic [C_SUM_W-1:0] L_NEG_LIM = C_SUM_W'(2 ** (C_STEPS_W - 1));

    logic [L_PW-1:0]    prod;
    logic [L_QW-1:0]    tenth;
    logic [C_SUM_W-1:0] total;
    logic [C_SUM_W-1:0] negv;

    always_comb begin
        prod  = L_PW'(i_mid.mag_prod) * L_PW'(C_RECIP_TEN);
        tenth = prod[C_RECIP_SH +: L_QW];
        total = C_SUM_W'(i_mid.mag_prod) + (i_mid.frac ? C_SUM_W'(tenth) : '0);
        negv  = '0 - total;
        if (i_mid.neg) begin
            if (total > L_NEG_LIM) begin
                o_steps = $signed(L_NEG_LIM[C_STEPS_W-1:0]);
            end else begin
                o_steps = $signed(negv[C_STEPS_W-1:0]);
            end
        end else begin
            if (total > L_POS_LIM) begin
                o_steps = $signed(L_POS_LIM[C_STEPS_W-1:0]);
            end else begin
                o_steps = $signed(total[C_STEPS_W-1:0]);
            end
        end
    end

endmodule

@@ rtl/needle_valve_position_controller_core.sv @@
// Top level of the needle valve position controller: configuration, pipeline and handshakes.
// One control tick is one input beat and gives one result beat. The block takes a beat on
// every clock while the result side does not stall. The beat passes the input register, the
// controller register and the result register in that order. The valve state, goal and
// move flags live in the controller and are updated in the cycle a beat leaves the input
// register, so consecutive beats see each other's effect without a gap. A stall on the
// result side holds every stage. The tenth of the overshoot is taken by a reciprocal
// multiply that is exact for STEPS_PER_COUNT up to 1024. The user must write configuration
// only while the pipeline is empty; the block itself does not enforce it.
module needle_valve_position_controller_core #(
    parameter int ENCODER_MAX     = 65535,
    parameter int ENCODER_MIN     = 0,
    parameter int STEPS_PER_COUNT = 250
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [nvpc_pkg::C_IDX_W-1:0]           i_cfg_idx,
    input  logic [nvpc_pkg::C_CFG_W-1:0]           i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_goal_command,
    input  logic                                   i_enable,
    input  logic [nvpc_pkg::C_POS_W-1:0]           i_position_reading,
    input  logic                                   i_drive_busy,
    input  logic                                   i_stop_accepted,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [1:0]                             o_drive_command,
    output logic signed [nvpc_pkg::C_STEPS_W-1:0]  o_move_steps,
    output logic [nvpc_pkg::C_CUR_W-1:0]           o_move_current,
    output logic [1:0]                             o_valve_state,
    output logic [1:0]                             o_valve_goal,
    output logic                                   o_is_moving
);
    import nvpc_pkg::*;

    t_cfg  r_cfg;
    logic  r_in_valid;
    t_item r_in;
    logic  r_mid_valid;
    t_mid  r_mid;
    t_mid  mid_next;
    logic  r_out_valid;
    logic  adv;
    logic  fire;

    logic signed [C_STEPS_W-1:0] steps;

    logic [1:0]                  r_dcmd;
    logic signed [C_STEPS_W-1:0] r_steps;
    logic [C_CUR_W-1:0]          r_cur;
    logic [1:0]                  r_vstate;
    logic [1:0]                  r_vgoal;
    logic                        r_moving;

    assign adv        = !(r_out_valid && i_out_stall);
    assign fire       = adv && r_in_valid;
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPEN_THR:    r_cfg.open_thr    <= i_cfg_wdata;
                CFG_LOOSE_THR:   r_cfg.loose_thr   <= i_cfg_wdata;
                CFG_CLOSED_THR:  r_cfg.closed_thr  <= i_cfg_wdata;
                CFG_MIN_TIGHTEN: r_cfg.min_tighten <= i_cfg_wdata;
                CFG_OPEN_CUR:    r_cfg.open_cur    <= i_cfg_wdata[C_CUR_W-1:0];
                CFG_CLOSE_CUR:   r_cfg.close_cur   <= i_cfg_wdata[C_CUR_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid  <= i_in_valid;
            r_mid_valid <= r_in_valid;
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in_valid) begin
            r_in.goal_command     <= i_goal_command;
            r_in.enable           <= i_enable;
            r_in.position_reading <= i_position_reading;
            r_in.drive_busy       <= i_drive_busy;
            r_in.stop_accepted    <= i_stop_accepted;
        end
        if (fire) begin
            r_mid <= mid_next;
        end
        if (adv && r_mid_valid) begin
            r_dcmd   <= r_mid.drive_command;
            r_steps  <= steps;
            r_cur    <= r_mid.move_current;
            r_vstate <= r_mid.valve_state;
            r_vgoal  <= r_mid.valve_goal;
            r_moving <= r_mid.is_moving;
        end
    end

    nvpc_ctrl #(
        .ENCODER_MAX     (ENCODER_MAX),
        .ENCODER_MIN     (ENCODER_MIN),
        .STEPS_PER_COUNT (STEPS_PER_COUNT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_mid   (mid_next)
    );

    nvpc_scale u_scale (
        .i_mid   (r_mid),
        .o_steps (steps)
    );

    assign o_out_valid     = r_out_valid;
    assign o_drive_command = r_dcmd;
    assign o_move_steps    = r_steps;
    assign o_move_current  = r_cur;
    assign o_valve_state   = r_vstate;
    assign o_valve_goal    = r_vgoal;
    assign o_is_moving     = r_moving;

    a_idle_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drive_command == DC_NONE || o_drive_command == DC_STOP)
        |-> (o_move_steps == 0) && (o_move_current == 0))
        else $error("step count or current set without a move");

    a_tighten_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drive_command == DC_STOP_MOVE)
        |-> (o_move_steps[C_STEPS_W-1] || o_move_steps == 0))
        else $error("tighten move runs in the opening direction");

    a_move_sets_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drive_command == DC_MOVE || o_drive_command == DC_STOP_MOVE)
        |-> o_is_moving)
        else $error("move issued without the moving flag");

endmodule

@@ test/needle_valve_position_controller_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the needle valve position controller core against result beats.
module needle_valve_position_controller_core_tb;
    import nvpc_pkg::*;

    typedef struct packed {
        logic [1:0]           drive_command;
        logic [C_STEPS_W-1:0] move_steps;
        logic [C_CUR_W-1:0]   move_current;
        logic [1:0]           valve_state;
        logic [1:0]           valve_goal;
        logic                 is_moving;
    } t_valve_result;

    class valve_tick_checker;
        localparam longint STEPS    = 250;
        localparam longint ENC_MAX  = 65535;
        localparam longint ENC_MIN  = 0;
        localparam longint STEPS_HI = 33554431;
        localparam longint STEPS_LO = -33554432;

        longint             open_thr, loose_thr, closed_thr, tighten_min;
        logic [C_CUR_W-1:0] open_cur, close_cur;
        logic [1:0]         state, last_state, goal;
        logic [2:0]         kind;
        bit                 moving, tightened;
        t_valve_result      due[$];
        int                 errors;

        function new();
            open_thr    = 0;
            loose_thr   = 0;
            closed_thr  = 0;
            tighten_min = 0;
            open_cur    = '0;
            close_cur   = '0;
            state       = ST_INTERMED;
            last_state  = ST_INTERMED;
            goal        = ST_INTERMED;
            kind        = MV_NONE;
            moving      = 1'b0;
            tightened   = 1'b1;
            errors      = 0;
        endfunction

        function void set_reg(logic [C_IDX_W-1:0] idx, logic [C_CFG_W-1:0] val);
            case (idx)
                CFG_OPEN_THR:    open_thr    = val;
                CFG_LOOSE_THR:   loose_thr   = val;
                CFG_CLOSED_THR:  closed_thr  = val;
                CFG_MIN_TIGHTEN: tighten_min = val;
                CFG_OPEN_CUR:    open_cur    = val[C_CUR_W-1:0];
                CFG_CLOSE_CUR:   close_cur   = val[C_CUR_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        function logic [C_STEPS_W-1:0] clamp_steps(longint v);
            if (v > STEPS_HI) v = STEPS_HI;
            if (v < STEPS_LO) v = STEPS_LO;
            return v[C_STEPS_W-1:0];
        endfunction

        function longint min_of(longint a, longint b);
            return (a < b) ? a : b;
        endfunction

        function void note_tick(t_item t);
            longint        pos;
            longint        over;
            logic [1:0]    goal_before;
            bit            fresh;
            bit            act;
            t_valve_result r;
            pos         = t.position_reading;
            goal_before = goal;
            r           = '0;
            if (t.goal_command == GC_OPEN) begin
                goal = ST_OPENED;
            end else if (t.goal_command == GC_CLOSE) begin
                goal = (state == ST_OPENED || state == ST_INTERMED) ? ST_LOOSE : ST_CLOSED;
            end
            if (pos <= closed_thr && tightened) begin
                state = ST_CLOSED;
            end else if (pos <= loose_thr) begin
                state = ST_LOOSE;
            end else if (pos >= open_thr) begin
                state = ST_OPENED;
            end else begin
                state = ST_INTERMED;
            end
            fresh      = (state != last_state);
            last_state = state;
            if (state == goal) begin
                kind   = MV_NONE;
                moving = 1'b0;
                if (state == ST_LOOSE) begin
                    goal = ST_CLOSED;
                    kind = MV_TIGHT;
                end
            end else if (!moving) begin
                if (state != ST_OPENED && goal == ST_OPENED) begin
                    kind = MV_OPEN;
                end else if (state != ST_CLOSED && (goal == ST_CLOSED || goal == ST_LOOSE)) begin
                    kind = MV_CLOSE;
                end
            end
            act = fresh || (goal_before != goal);
            if (!t.enable) begin
                act  = 1'b1;
                kind = MV_STOP;
                goal = ST_INTERMED;
            end
            if (act) begin
                case (kind)
                    MV_STOP: begin
                        r.drive_command = DC_STOP;
                        if (t.stop_accepted) moving = 1'b0;
                    end
                    MV_NONE: begin
                        if (state != ST_CLOSED) r.drive_command = DC_STOP;
                        moving = 1'b0;
                    end
                    MV_OPEN: begin
                        r.drive_command = DC_MOVE;
                        r.move_current  = open_cur;
                        r.move_steps    = clamp_steps(min_of(STEPS * 11 * (open_thr - pos),
                                                             STEPS * 10 * (ENC_MAX - pos)) / 10);
                        moving          = 1'b1;
                        tightened       = 1'b0;
                    end
                    MV_CLOSE: begin
                        r.drive_command = DC_MOVE;
                        r.move_current  = close_cur;
                        r.move_steps    = clamp_steps(-(min_of(STEPS * 11 * (pos - loose_thr),
                                                               STEPS * 10 * (pos - ENC_MIN)) / 10));
                        moving          = 1'b1;
                    end
                    MV_TIGHT: begin
                        if (!moving) begin
                            over = pos - closed_thr;
                            if (over < 0) over = 0;
                            r.drive_command = DC_STOP_MOVE;
                            r.move_current  = close_cur;
                            r.move_steps    = clamp_steps(-STEPS * over - STEPS * tighten_min);
                            tightened       = 1'b1;
                            moving          = 1'b1;
                        end else if (!t.drive_busy) begin
                            moving = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            r.valve_state = state;
            r.valve_goal  = goal;
            r.is_moving   = moving;
            due.push_back(r);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_valve_result got);
            t_valve_result want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: result beat expected none actual %p", $time, got);
                return;
            end
            want = due.pop_front();
            check_field("drive_command", want.drive_command, got.drive_command);
            check_field("move_steps", $signed(want.move_steps), $signed(got.move_steps));
            check_field("move_current", want.move_current, got.move_current);
            check_field("valve_state", want.valve_state, got.valve_state);
            check_field("valve_goal", want.valve_goal, got.valve_goal);
            check_field("is_moving", want.is_moving, got.is_moving);
        endfunction
    endclass

    localparam logic [1:0] GC_UNUSED    = 2'd3;
    localparam int         RANDOM_TICKS = 1050;
    localparam int         PHASE_TICKS  = 130;
    localparam int         QUIET_LIMIT  = 1000;

    logic                        i_clk              = 1'b0;
    logic                        i_rst_n            = 1'b0;
    logic                        i_cfg_we           = 1'b0;
    logic [C_IDX_W-1:0]          i_cfg_idx          = '0;
    logic [C_CFG_W-1:0]          i_cfg_wdata        = '0;
    logic                        i_in_valid         = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_goal_command     = GC_KEEP;
    logic                        i_enable           = 1'b0;
    logic [C_POS_W-1:0]          i_position_reading = '0;
    logic                        i_drive_busy       = 1'b0;
    logic                        i_stop_accepted    = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall        = 1'b0;
    logic [1:0]                  o_drive_command;
    logic signed [C_STEPS_W-1:0] o_move_steps;
    logic [C_CUR_W-1:0]          o_move_current;
    logic [1:0]                  o_valve_state;
    logic [1:0]                  o_valve_goal;
    logic                        o_is_moving;

    valve_tick_checker tick_check;
    bit                steady      = 1'b0;
    int                ticks_sent  = 0;
    int                quiet_count = 0;
    int                valve_pos   = 0;

    needle_valve_position_controller_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_goal_command     (i_goal_command),
        .i_enable           (i_enable),
        .i_position_reading (i_position_reading),
        .i_drive_busy       (i_drive_busy),
        .i_stop_accepted    (i_stop_accepted),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_drive_command    (o_drive_command),
        .o_move_steps       (o_move_steps),
        .o_move_current     (o_move_current),
        .o_valve_state      (o_valve_state),
        .o_valve_goal       (o_valve_goal),
        .o_is_moving        (o_is_moving)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_item         item;
        t_valve_result got;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            item = {i_goal_command, i_enable, i_position_reading, i_drive_busy, i_stop_accepted};
            tick_check.note_tick(item);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_drive_command, o_move_steps, o_move_current, o_valve_state, o_valve_goal,
                   o_is_moving};
            tick_check.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_count = 0;
        end else begin
            quiet_count++;
        end
        if (quiet_count >= QUIET_LIMIT) begin
            $display("needle_valve_position_controller_core: mismatch");
            $finish;
        end
    end

    initial begin : result_sink
        int hold;
        forever begin
            hold = steady ? 0 : $urandom_range(0, 8);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic put_reg(logic [C_IDX_W-1:0] idx, logic [C_CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tick_check.set_reg(idx, val);
    endtask

    task automatic load_config(int open_thr, int loose_thr, int closed_thr, int tighten_min,
                               int open_cur, int close_cur);
        put_reg(CFG_OPEN_THR, C_CFG_W'(open_thr));
        put_reg(CFG_LOOSE_THR, C_CFG_W'(loose_thr));
        put_reg(CFG_CLOSED_THR, C_CFG_W'(closed_thr));
        put_reg(CFG_MIN_TIGHTEN, C_CFG_W'(tighten_min));
        put_reg(CFG_OPEN_CUR, C_CFG_W'(open_cur));
        put_reg(CFG_CLOSE_CUR, C_CFG_W'(close_cur));
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tick_check.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_tick(logic [1:0] cmd, logic en, logic [C_POS_W-1:0] pos, logic busy,
                             logic stop_ok);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_goal_command     <= cmd;
        i_enable           <= en;
        i_position_reading <= pos;
        i_drive_busy       <= busy;
        i_stop_accepted    <= stop_ok;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ticks_sent++;
    endtask

    function automatic int pick_position();
        int base;
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2: base = int'(tick_check.open_thr);
            3: base = int'(tick_check.loose_thr);
            4: base = int'(tick_check.closed_thr);
            default: return $urandom_range(0, 65535);
        endcase
        base = base + int'($urandom_range(0, 2)) - 1;
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        return base;
    endfunction

    task automatic noise_tick();
        int         pick;
        logic [1:0] cmd;
        pick = $urandom_range(0, 15);
        if (pick < 10) begin
            cmd = GC_KEEP;
        end else if (pick < 12) begin
            cmd = GC_OPEN;
        end else if (pick < 14) begin
            cmd = GC_CLOSE;
        end else begin
            cmd = GC_UNUSED;
        end
        valve_pos = pick_position();
        send_tick(cmd, $urandom_range(0, 7) != 0, C_POS_W'(valve_pos),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic stroke(bit to_open);
        int from_pos;
        int target;
        int legs;
        from_pos = valve_pos;
        target   = to_open ? $urandom_range(int'(tick_check.open_thr), 65535)
                           : $urandom_range(0, int'(tick_check.closed_thr));
        legs     = $urandom_range(2, 10);
        send_tick(to_open ? GC_OPEN : GC_CLOSE, 1'b1, C_POS_W'(from_pos), 1'b0, 1'b1);
        for (int k = 1; k <= legs; k++) begin
            send_tick(GC_KEEP, $urandom_range(0, 19) != 0,
                      C_POS_W'(from_pos + (target - from_pos) * k / legs), k < legs,
                      $urandom_range(0, 3) != 0);
        end
        repeat ($urandom_range(1, 3)) begin
            send_tick(GC_KEEP, 1'b1, C_POS_W'(target), 1'($urandom_range(0, 1)), 1'b1);
        end
        valve_pos = target;
    endtask

    initial begin : stimulus
        int phase;
        int phase_end;
        int closed_thr;
        int loose_thr;
        tick_check = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_config(40000, 10000, 2000, 100, 16'h00A5, 16'h005A);

        send_tick(GC_KEEP, 1'b0, 20000, 1'b0, 1'b0);
        send_tick(GC_KEEP, 1'b0, 20000, 1'b0, 1'b1);
        send_tick(GC_UNUSED, 1'b1, 20000, 1'b0, 1'b1);
        send_tick(GC_OPEN, 1'b1, 0, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 20000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 65535, 1'b0, 1'b1);
        send_tick(GC_CLOSE, 1'b1, 65535, 1'b0, 1'b1);
        send_tick(GC_KEEP, 1'b1, 30000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 9000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 5000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 20000, 1'b0, 1'b1);
        send_tick(GC_KEEP, 1'b1, 9000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 9000, 1'b0, 1'b1);
        send_tick(GC_KEEP, 1'b1, 5000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 1500, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b1, 0, 1'b0, 1'b1);
        send_tick(GC_CLOSE, 1'b1, 0, 1'b0, 1'b1);
        send_tick(GC_OPEN, 1'b1, 1000, 1'b1, 1'b1);
        send_tick(GC_KEEP, 1'b0, 25000, 1'b1, 1'b0);
        send_tick(GC_KEEP, 1'b0, 25000, 1'b1, 1'b1);
        send_tick(GC_CLOSE, 1'b1, 25000, 1'b0, 1'b1);
        valve_pos = 25000;

        phase = 0;
        while (ticks_sent < RANDOM_TICKS) begin
            settle();
            closed_thr = $urandom_range(0, 20000);
            loose_thr  = closed_thr + $urandom_range(0, 20000);
            case (phase % 6)
                0: load_config(0, 0, 0, 0, 0, 0);
                1: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2, 3: load_config(loose_thr + $urandom_range(1, 25000), loose_thr, closed_thr,
                                  $urandom_range(0, 2000), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
                4: load_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535));
                default: load_config(loose_thr + $urandom_range(1, 25000), loose_thr, 0,
                                     16'hFFFF, 16'h00FF, 16'h00FF);
            endcase
            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end && ticks_sent < RANDOM_TICKS) begin
                steady = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) < 7) begin
                    stroke(1'($urandom_range(0, 1)));
                end else begin
                    repeat ($urandom_range(1, 6)) noise_tick();
                end
                if ($urandom_range(0, 49) == 0) settle();
            end
            phase++;
        end
        steady = 1'b0;
        settle();

        if (tick_check.errors == 0 && tick_check.pending() == 0) begin
            $display("needle_valve_position_controller_core: match");
        end else begin
            $display("needle_valve_position_controller_core: mismatch");
        end
        $finish;
    end
endmodule
